### rtl/bcs_pkg.sv
// Package for the bicubic image sampler: parameter defaults, fixed port widths,
// register indexes, transaction kinds and the sequencer state type. No dependencies.
`default_nettype none
package bcs_pkg;
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int PIXEL_BITS_DEF = 16;

   localparam int COORD_BITS  = 8;
   localparam int PIXEL_IN_BITS = 16;
   localparam int QUERY_BITS  = 18;
   localparam int SAMPLE_BITS = 25;
   localparam int CSR_BITS    = 9;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [CSR_BITS-1:0] SIZE_RESET = 9'd256;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_COL,
      ST_ROW
   } state_type;
endpackage
`default_nettype wire

### rtl/bcs_mac.sv
// Shared multiply, round and add step of the cubic evaluation:
// res = addend + round(t * op / 2^s), s = F or F+1. Depends on nothing.
`default_nettype none
module bcs_mac #(
   parameter int W = 36,
   parameter int F = 8
) (
   input  wire logic [F-1:0]        t,
   input  wire logic signed [W-1:0] op,
   input  wire logic signed [W-1:0] addend,
   input  wire logic                wide_shift,
   output logic signed [W-1:0]      res
);
   localparam int PW = W + F + 1;
   localparam logic signed [PW-1:0] HALF_N = PW'(1) <<< (F - 1);
   localparam logic signed [PW-1:0] HALF_W = PW'(1) <<< F;

   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] rounded;
   logic signed [PW-1:0] shifted;

   always_comb begin
      prod    = PW'($signed({1'b0, t})) * PW'(op);
      rounded = prod + (wide_shift ? HALF_W : HALF_N);
      shifted = wide_shift ? (rounded >>> (F + 1)) : (rounded >>> F);
      res     = addend + $signed(shifted[W-1:0]);
   end
endmodule
`default_nettype wire

### rtl/bicubic_image_sampler.sv
// Bicubic (Catmull-Rom) image sampler top level: pixel store, fetch sequencer, cubic datapath.
// Depends on bcs_pkg and bcs_mac.
// Pixel write: taken without raising busy, a new transaction may follow in the next cycle.
// Query: busy for four columns, each a fetch from the single-port memory followed by
// evaluation on the shared multiply unit, then for the row pass. Strobe one cycle wide,
// in the cycle in which busy falls. Reset: sync, sizes return to 256, image contents kept.
`default_nettype none
module bicubic_image_sampler #(
   parameter int MAX_WIDTH  = bcs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bcs_pkg::MAX_HEIGHT_DEF,
   parameter int FRAC_BITS  = bcs_pkg::FRAC_BITS_DEF,
   parameter int PIXEL_BITS = bcs_pkg::PIXEL_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic                                   req_kind,
   input  wire logic [bcs_pkg::COORD_BITS-1:0]         req_pixel_col,
   input  wire logic [bcs_pkg::COORD_BITS-1:0]         req_pixel_row,
   input  wire logic signed [bcs_pkg::PIXEL_IN_BITS-1:0] req_pixel_value,
   input  wire logic signed [bcs_pkg::QUERY_BITS-1:0]  req_query_x,
   input  wire logic signed [bcs_pkg::QUERY_BITS-1:0]  req_query_y,
   output logic                                        rsp_valid,
   output logic signed [bcs_pkg::SAMPLE_BITS-1:0]      rsp_sample_value,
   input  wire logic                                   csr_write_enable,
   input  wire logic                                   csr_index,
   input  wire logic [bcs_pkg::CSR_BITS-1:0]           csr_write_data
);
   localparam int F     = FRAC_BITS;
   localparam int PB    = PIXEL_BITS;
   localparam int W     = PB + F + 12;
   localparam int QB    = bcs_pkg::QUERY_BITS;
   localparam int CW    = QB + 1 - F;
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int CMPW  = ((CW + 1) > 14 ? (CW + 1) : 14) + 1;
   localparam int IB    = bcs_pkg::PIXEL_IN_BITS;
   localparam int SW    = ((IB > PB) ? IB : PB) + 1;
   localparam int OW    = bcs_pkg::SAMPLE_BITS;
   localparam int RW    = ((W > OW) ? W : OW) + 1;

   localparam logic signed [SW-1:0] PMAX = SW'((64'sd1 <<< (PB - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);
   localparam logic signed [RW-1:0] OMAX = RW'((64'sd1 <<< (OW - 1)) - 64'sd1);
   localparam logic signed [RW-1:0] OMIN = -OMAX - RW'(1);
   localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);
   localparam logic [CMPW-1:0] MAXH_C = CMPW'(MAX_HEIGHT);
   localparam logic signed [QB:0] ONE = (QB + 1)'(1) <<< F;

   bcs_pkg::state_type state_ff, state_in;
   logic [1:0] col_ff, col_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] step_ff, step_in;

   logic [F-1:0] tx_ff, ty_ff;
   logic signed [CW-1:0] ix_ff, iy_ff;
   logic signed [W-1:0] q_ff [4];
   logic signed [W-1:0] colv_ff [3];
   logic signed [W-1:0] h_ff;
   logic [PB-1:0] rd_ff;
   logic rd_ok_ff;
   logic rsp_valid_ff;
   logic signed [OW-1:0] rsp_ff;
   logic [bcs_pkg::CSR_BITS-1:0] width_ff, height_ff;

   logic [PB-1:0] mem [DEPTH];

   logic accept, wr_en, fetch_ok;
   logic signed [QB:0] xs, ys;
   logic signed [CW:0] c_pos, r_pos;
   logic signed [CMPW-1:0] ce, re;
   logic [CMPW-1:0] w_eff, h_eff, wc, wr;
   logic [AW-1:0] rd_addr, wr_addr, mem_addr;
   logic signed [SW-1:0] pix_ext, pix_sat;
   logic signed [W-1:0] fetched, a_t, b_t, c_t, mac_op, mac_add, mac_res;
   logic [F-1:0] mac_t;
   logic mac_wide;
   logic signed [RW-1:0] res_ext;
   logic [1:0] q_idx;

   assign busy = (state_ff != bcs_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_value = rsp_ff;
   assign accept = start & ~busy;

   always_comb begin
      xs = (QB + 1)'(req_query_x) - ONE;
      ys = (QB + 1)'(req_query_y) - ONE;

      w_eff = (CMPW'(width_ff) > MAXW_C) ? MAXW_C : CMPW'(width_ff);
      h_eff = (CMPW'(height_ff) > MAXH_C) ? MAXH_C : CMPW'(height_ff);
      c_pos = (CW + 1)'(ix_ff) + $signed((CW + 1)'(col_ff));
      r_pos = (CW + 1)'(iy_ff) + $signed((CW + 1)'(cnt_ff[1:0]));
      ce = CMPW'(c_pos);
      re = CMPW'(r_pos);
      fetch_ok = ~ce[CMPW-1] && ~re[CMPW-1] && ($unsigned(ce) < w_eff)
                 && ($unsigned(re) < h_eff);
      rd_addr = AW'(AW'($unsigned(re)) * AW'(MAX_WIDTH) + AW'($unsigned(ce)));

      wc = CMPW'(req_pixel_col);
      wr = CMPW'(req_pixel_row);
      wr_en = accept && (req_kind == bcs_pkg::KIND_WRITE) && (wc < MAXW_C) && (wr < MAXH_C);
      wr_addr = AW'(AW'(req_pixel_row) * AW'(MAX_WIDTH) + AW'(req_pixel_col));
      mem_addr = wr_en ? wr_addr : rd_addr;

      pix_ext = SW'(req_pixel_value);
      priority if (pix_ext > PMAX) begin
         pix_sat = PMAX;
      end else if (pix_ext < PMIN) begin
         pix_sat = PMIN;
      end else begin
         pix_sat = pix_ext;
      end

      fetched = rd_ok_ff ? $signed({{(W - PB - F){rd_ff[PB-1]}}, rd_ff, {F{1'b0}}}) : '0;
      q_idx = cnt_ff[1:0] - 2'd1;

      a_t = q_ff[2] - q_ff[0];
      b_t = (q_ff[0] <<< 1) - (q_ff[1] <<< 2) - q_ff[1] + (q_ff[2] <<< 2) - q_ff[3];
      c_t = (q_ff[1] <<< 1) + q_ff[1] - (q_ff[2] <<< 1) - q_ff[2] + q_ff[3] - q_ff[0];

      mac_t = (state_ff == bcs_pkg::ST_ROW) ? tx_ff : ty_ff;
      mac_wide = (step_ff == 2'd2);
      unique case (step_ff)
         2'd0: begin
            mac_op = c_t;
            mac_add = b_t;
         end
         2'd1: begin
            mac_op = h_ff;
            mac_add = a_t;
         end
         default: begin
            mac_op = h_ff;
            mac_add = q_ff[1];
         end
      endcase

      res_ext = RW'(mac_res);
   end

   bcs_mac #(.W(W), .F(F)) u_mac (
      .t(mac_t),
      .op(mac_op),
      .addend(mac_add),
      .wide_shift(mac_wide),
      .res(mac_res)
   );

   always_comb begin
      state_in = state_ff;
      col_in = col_ff;
      cnt_in = cnt_ff;
      step_in = step_ff;
      unique case (state_ff)
         bcs_pkg::ST_IDLE: begin
            if (accept && (req_kind == bcs_pkg::KIND_QUERY)) begin
               state_in = bcs_pkg::ST_FETCH;
               col_in = 2'd0;
               cnt_in = 3'd0;
            end
         end
         bcs_pkg::ST_FETCH: begin
            if (cnt_ff == 3'd4) begin
               state_in = bcs_pkg::ST_COL;
               step_in = 2'd0;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         bcs_pkg::ST_COL: begin
            if (step_ff == 2'd2) begin
               step_in = 2'd0;
               if (col_ff == 2'd3) begin
                  state_in = bcs_pkg::ST_ROW;
               end else begin
                  state_in = bcs_pkg::ST_FETCH;
                  col_in = col_ff + 2'd1;
                  cnt_in = 3'd0;
               end
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         bcs_pkg::ST_ROW: begin
            if (step_ff == 2'd2) begin
               state_in = bcs_pkg::ST_IDLE;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         default: state_in = bcs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcs_pkg::ST_IDLE;
         col_ff <= 2'd0;
         cnt_ff <= 3'd0;
         step_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         col_ff <= col_in;
         cnt_ff <= cnt_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= bcs_pkg::SIZE_RESET;
         height_ff <= bcs_pkg::SIZE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bcs_pkg::CSR_IMAGE_WIDTH:  width_ff <= csr_write_data;
            bcs_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[mem_addr] <= pix_sat[PB-1:0];
      end else if (state_ff == bcs_pkg::ST_FETCH) begin
         rd_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      rd_ok_ff <= fetch_ok;
      if (state_ff == bcs_pkg::ST_IDLE && accept) begin
         ix_ff <= CW'(xs >>> F);
         iy_ff <= CW'(ys >>> F);
         tx_ff <= xs[F-1:0];
         ty_ff <= ys[F-1:0];
      end
      if (state_ff == bcs_pkg::ST_FETCH && cnt_ff != 3'd0) begin
         q_ff[q_idx] <= fetched;
      end
      if (state_ff == bcs_pkg::ST_COL || state_ff == bcs_pkg::ST_ROW) begin
         h_ff <= mac_res;
      end
      if (state_ff == bcs_pkg::ST_COL && step_ff == 2'd2) begin
         if (col_ff == 2'd3) begin
            q_ff[0] <= colv_ff[0];
            q_ff[1] <= colv_ff[1];
            q_ff[2] <= colv_ff[2];
            q_ff[3] <= mac_res;
         end else begin
            colv_ff[col_ff] <= mac_res;
         end
      end
      if (state_ff == bcs_pkg::ST_ROW && step_ff == 2'd2) begin
         priority if (res_ext > OMAX) begin
            rsp_ff <= OMAX[OW-1:0];
         end else if (res_ext < OMIN) begin
            rsp_ff <= OMIN[OW-1:0];
         end else begin
            rsp_ff <= res_ext[OW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == bcs_pkg::ST_ROW) && (step_ff == 2'd2);
      end
   end
endmodule
`default_nettype wire

### rtl/bcs_checker.sv
// Port-level checks for the bicubic image sampler, bound to the top level.
// Depends on bcs_pkg and bicubic_image_sampler.
`default_nettype none
module bcs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_kind,
   input wire logic rsp_valid
);
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == bcs_pkg::KIND_QUERY) |=> busy)
      else $error("query transaction did not raise busy");

   a_write_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == bcs_pkg::KIND_WRITE) |=> !busy)
      else $error("pixel write transaction raised busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");
endmodule

bind bicubic_image_sampler bcs_checker u_bcs_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_kind(req_kind),
   .rsp_valid(rsp_valid)
);
`default_nettype wire

### verif/tb_bicubic_image_sampler.sv
// Testbench for bicubic_image_sampler: pixel writes and Catmull-Rom queries checked
// against an internal image copy and predictor. Depends on bcs_pkg and the RTL.
`timescale 1ns / 100ps
module tb_bicubic_image_sampler;
   localparam int  FRAC = bcs_pkg::FRAC_BITS_DEF;
   localparam int  ONE = 1 << FRAC;
   localparam int  CSR_SETTLE = 40;
   localparam int  NEAR_SPAN = 24;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = bcs_pkg::KIND_WRITE;
   logic [bcs_pkg::COORD_BITS-1:0] req_pixel_col = '0;
   logic [bcs_pkg::COORD_BITS-1:0] req_pixel_row = '0;
   logic signed [bcs_pkg::PIXEL_IN_BITS-1:0] req_pixel_value = '0;
   logic signed [bcs_pkg::QUERY_BITS-1:0] req_query_x = '0;
   logic signed [bcs_pkg::QUERY_BITS-1:0] req_query_y = '0;
   logic rsp_valid;
   logic signed [bcs_pkg::SAMPLE_BITS-1:0] rsp_sample_value;
   logic csr_write_enable = 1'b0;
   logic csr_index = bcs_pkg::CSR_IMAGE_WIDTH;
   logic [bcs_pkg::CSR_BITS-1:0] csr_write_data = '0;

   bicubic_image_sampler i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_pixel_col(req_pixel_col), .req_pixel_row(req_pixel_row),
      .req_pixel_value(req_pixel_value), .req_query_x(req_query_x),
      .req_query_y(req_query_y), .rsp_valid(rsp_valid),
      .rsp_sample_value(rsp_sample_value), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data)
   );

   logic signed [bcs_pkg::PIXEL_IN_BITS-1:0] image_copy [0:255][0:255];
   bit written [0:255][0:255];
   logic [bcs_pkg::CSR_BITS-1:0] width_reg = bcs_pkg::SIZE_RESET;
   logic [bcs_pkg::CSR_BITS-1:0] height_reg = bcs_pkg::SIZE_RESET;
   logic signed [bcs_pkg::SAMPLE_BITS-1:0] expected_samples[$];
   int error_count = 0;
   int sender_idle_pct = 0;
   longint cycle_count = 0;

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int eff_width();
      return (width_reg > 256) ? 256 : int'(width_reg);
   endfunction

   function automatic int eff_height();
      return (height_reg > 256) ? 256 : int'(height_reg);
   endfunction

   function automatic longint pixel_at(longint c, longint r);
      if (c < 0 || r < 0 || c >= eff_width() || r >= eff_height())
         return 0;
      return longint'(image_copy[r][c]);
   endfunction

   function automatic longint round_shift(longint p, int s);
      return (p + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint catmull_rom(longint v0, longint v1, longint v2, longint v3,
                                          longint t);
      longint a, b, c, h2, h1;
      a = v2 - v0;
      b = 2 * v0 - 5 * v1 + 4 * v2 - v3;
      c = 3 * (v1 - v2) + v3 - v0;
      h2 = b + round_shift(t * c, FRAC);
      h1 = a + round_shift(t * h2, FRAC);
      return v1 + round_shift(t * h1, FRAC + 1);
   endfunction

   function automatic logic signed [bcs_pkg::SAMPLE_BITS-1:0] bicubic_sample(
         logic signed [bcs_pkg::QUERY_BITS-1:0] qx,
         logic signed [bcs_pkg::QUERY_BITS-1:0] qy);
      longint xs, ys, ix, iy, tx, ty, r;
      longint cols [4];
      xs = longint'(qx) - ONE;
      ys = longint'(qy) - ONE;
      ix = xs >>> FRAC;
      iy = ys >>> FRAC;
      tx = xs - ix * ONE;
      ty = ys - iy * ONE;
      for (int i = 0; i < 4; i++)
         cols[i] = catmull_rom(pixel_at(ix + i, iy) * ONE, pixel_at(ix + i, iy + 1) * ONE,
                               pixel_at(ix + i, iy + 2) * ONE, pixel_at(ix + i, iy + 3) * ONE,
                               ty);
      r = catmull_rom(cols[0], cols[1], cols[2], cols[3], tx);
      if (r > 16777215) r = 16777215;
      if (r < -16777216) r = -16777216;
      return r[bcs_pkg::SAMPLE_BITS-1:0];
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_samples.size() == 0)
            report_mismatch($sformatf("unexpected sample %0d", rsp_sample_value));
         else begin
            if (rsp_sample_value !== expected_samples[0])
               report_mismatch($sformatf("sample_value got %0d expected %0d",
                                         rsp_sample_value, expected_samples[0]));
            void'(expected_samples.pop_front());
         end
      end
   end

   // Leaves start high so back-to-back transactions keep it asserted.
   task automatic send_item(logic kind, logic [7:0] col, logic [7:0] row,
                            logic signed [15:0] value, logic signed [17:0] qx,
                            logic signed [17:0] qy);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_pixel_col <= col;
      req_pixel_row <= row;
      req_pixel_value <= value;
      req_query_x <= qx;
      req_query_y <= qy;
      do @(posedge clock); while (busy);
      if (kind == bcs_pkg::KIND_WRITE) begin
         image_copy[row][col] = value;
         written[row][col] = 1'b1;
      end else
         expected_samples.push_back(bicubic_sample(qx, qy));
   endtask

   task automatic write_pixel(int col, int row, logic signed [15:0] value);
      send_item(bcs_pkg::KIND_WRITE, col[7:0], row[7:0], value, 18'($urandom),
                18'($urandom));
   endtask

   // Loads any pixel of the 4x4 neighborhood inside the image that was never written, then sends the query.
   task automatic query_at(logic signed [17:0] qx, logic signed [17:0] qy);
      longint ix, iy;
      ix = (longint'(qx) - ONE) >>> FRAC;
      iy = (longint'(qy) - ONE) >>> FRAC;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            if (ix + c >= 0 && iy + r >= 0 && ix + c < eff_width() && iy + r < eff_height())
               if (!written[iy + r][ix + c])
                  write_pixel(int'(ix + c), int'(iy + r), 16'($urandom));
      send_item(bcs_pkg::KIND_QUERY, 8'($urandom), 8'($urandom), 16'($urandom), qx, qy);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
   endtask

   task automatic set_size(int w, int h);
      drain();
      repeat (CSR_SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= bcs_pkg::CSR_IMAGE_WIDTH;
      csr_write_data <= w[bcs_pkg::CSR_BITS-1:0];
      @(posedge clock);
      width_reg = w[bcs_pkg::CSR_BITS-1:0];
      csr_index <= bcs_pkg::CSR_IMAGE_HEIGHT;
      csr_write_data <= h[bcs_pkg::CSR_BITS-1:0];
      @(posedge clock);
      height_reg = h[bcs_pkg::CSR_BITS-1:0];
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [17:0] near_coord(int extent);
      int span;
      span = (extent > NEAR_SPAN) ? NEAR_SPAN : extent;
      if ($urandom_range(4) == 0) return 18'($urandom);
      return 18'($urandom_range(0, (span + 4) * ONE) - 2 * ONE);
   endfunction

   task automatic test_directed();
      sender_idle_pct = 0;
      set_size(4, 4);
      write_pixel(1, 1, 16'sh7fff);
      write_pixel(2, 1, -16'sh8000);
      write_pixel(255, 255, 16'sh7fff);
      write_pixel(0, 0, -16'sh8000);
      query_at(18'sd256, 18'sd256);
      query_at(18'sd512, 18'sd512);
      query_at(18'sd640, 18'sd384);
      query_at(18'sd767, 18'sd511);
      query_at(18'sh1ffff, 18'sh1ffff);
      query_at(18'sh20000, 18'sh20000);
      query_at(18'sd0, -18'sd1);
      query_at(18'sd1279, 18'sd1279);
      send_item(bcs_pkg::KIND_QUERY, 8'hff, 8'hff, 16'hffff, 18'sd300, 18'sd700);
      send_item(bcs_pkg::KIND_WRITE, 8'd3, 8'd3, 16'h5a5a, 18'sh3ffff, 18'sh3ffff);
      query_at(18'sd1024, 18'sd1024);
      set_size(0, 0);
      query_at(18'sd512, 18'sd512);
      set_size(511, 511);
      query_at(18'sd65408, 18'sd65408);
      query_at(18'sd128, 18'sd128);
      query_at(18'sd32768, 18'sd200);
   endtask

   task automatic test_random(int idle_pct, int w, int h, int count);
      int ew, eh;
      set_size(w, h);
      sender_idle_pct = idle_pct;
      ew = eff_width();
      eh = eff_height();
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) drain();
         if ($urandom_range(9) < 3) begin
            if (ew > 0 && eh > 0 && $urandom_range(3) != 0)
               write_pixel($urandom_range(ew - 1), $urandom_range(eh - 1), 16'($urandom));
            else
               write_pixel($urandom_range(255), $urandom_range(255), 16'($urandom));
         end else
            query_at(near_coord(ew), near_coord(eh));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(35, 13, 9, 160);
      test_random(35, 256, 1, 160);
      test_random(79, 1, 256, 160);
      test_random(79, 0, 5, 160);
      test_random(79, 511, 2, 160);
      test_random(0, 300, 3, 160);
      test_random(0, 7, 511, 160);
      drain();
      repeat (CSR_SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

### sim.f
rtl/bcs_pkg.sv
rtl/bcs_mac.sv
rtl/bicubic_image_sampler.sv
rtl/bcs_checker.sv
verif/tb_bicubic_image_sampler.sv
